// ----- sv/sba_pkg.sv -----
// ============================================================================
// sba_pkg
// Shared types, constants and command codes of the spectrum bin averager.
// ============================================================================
package sba_pkg;

  localparam int BINS   = 1024;
  localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int BIN_W  = 10;

  // divider geometry: 2 quotient bits per cycle
  localparam int DVD_W     = 50;
  localparam int DVS_W     = 17;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // input function codes
  localparam logic [1:0] FN_ACC    = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_IGNORE = 2'd3;

  // mode register codes
  localparam logic [2:0] MD_NONE = 3'd0;
  localparam logic [2:0] MD_LIN  = 3'd1;
  localparam logic [2:0] MD_EXP  = 3'd2;
  localparam logic [2:0] MD_PEAK = 3'd3;
  localparam logic [2:0] MD_ENRG = 3'd4;

  // register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_MAX  = 1'b1;

  // classified operation codes
  localparam logic [3:0] OP_PASS  = 4'd0;
  localparam logic [3:0] OP_LIN   = 4'd1;
  localparam logic [3:0] OP_EXP   = 4'd2;
  localparam logic [3:0] OP_PEAK  = 4'd3;
  localparam logic [3:0] OP_ENRG  = 4'd4;
  localparam logic [3:0] OP_HOLD  = 4'd5;
  localparam logic [3:0] OP_READ  = 4'd6;
  localparam logic [3:0] OP_RMS   = 4'd7;
  localparam logic [3:0] OP_CLEAR = 4'd8;
  localparam logic [3:0] OP_NOP   = 4'd9;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [3:0]         op;
    logic               frame_end;
    logic               inrange;
    addr_t              addr;
    logic signed [23:0] sample;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic addr_t bin_addr(input logic [BIN_W-1:0] b);
    logic [31:0] w;
    w = 32'(b);
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic bin_ok(input logic [BIN_W-1:0] b);
    return 33'(b) < 33'(BINS);
  endfunction

endpackage

// ----- sv/sba_in_if.sv -----
// ============================================================================
// sba_in_if
// Input item channel: valid/ready handshake with the item fields.
// ============================================================================
interface sba_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [9:0]         bin;
  logic signed [23:0] sample;
  logic               last_bin;

  modport source (output valid, func, bin, sample, last_bin, input ready);
  modport sink (input valid, func, bin, sample, last_bin, output ready);
endinterface

// ----- sv/sba_out_if.sv -----
// ============================================================================
// sba_out_if
// Result channel: valid/ready handshake with the result fields.
// ============================================================================
interface sba_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] value;
  logic [15:0]        frames_done;
  logic               completed;

  modport source (output valid, value, frames_done, completed, input ready);
  modport sink (input valid, value, frames_done, completed, output ready);
endinterface

// ----- sv/spectrum_bin_averager.sv -----
// ============================================================================
// spectrum_bin_averager
// Averages spectrum frames per bin: linear, exponential, peak hold, rms.
// ============================================================================
// Path (accept to result valid): front register, queue, then read, calc,
//   distance, divide (2 quotient bits a cycle), add, write for divided
//   accumulates; read, calc, 24-step root for energetic reads; read, calc, write
//   for peak hold and exponential with max_averages=0; read, calc for reads and
//   undefined modes; straight to finish for pass-through, clear and ignored items.
// Back end takes one item at a time; front and 2-entry queue keep accepting.
// Reset: synchronous; mode=linear, max_averages=0, count and flag cleared,
//   then a sweep zeroes all BINS (1024) entries; a clear item does the same.

module spectrum_bin_averager
  import sba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sba_in_if.sink      item,
  sba_out_if.source   result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [2:0]  mode;
  logic [15:0] max_averages;

  // front to queue
  logic     push_valid;
  logic     push_ready;
  cmd_t     push_cmd;
  // queue to back end
  logic     pop_valid;
  logic     pop_ready;
  cmd_t     pop_cmd;
  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // user must keep writes to idle (not enforced) so classified commands stay valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MD_LIN;
      max_averages <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode <= cfg_data[2:0];
        CFG_MAX:  max_averages <= cfg_data;
        default:  mode <= mode;
      endcase
    end
  end

  // front: takes the transaction, decodes func and mode into a command
  sba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // divides |x - s| or |x*x - s| by frame count + 1 or max_averages
  sba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back end: bin store, arithmetic sequencer, result register
  sba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .max_averages (max_averages),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result       (result)
  );

endmodule

// ----- sv/sba_front.sv -----
// ============================================================================
// sba_front
// Accepts input transactions and classifies them into back-end commands.
// ============================================================================
module sba_front
  import sba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  mode,
  sba_in_if.sink      item,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_cmd
);

  logic held;
  cmd_t cmd;
  cmd_t cls;

  assign item.ready = !held || push_ready;
  assign push_valid = held;
  assign push_cmd   = cmd;

  always_comb begin
    cls.addr      = bin_addr(item.bin);
    cls.inrange   = bin_ok(item.bin);
    cls.sample    = item.sample;
    cls.frame_end = (item.func == FN_ACC) && item.last_bin;
    case (item.func)
      FN_ACC: begin
        case (mode)
          MD_NONE: cls.op = OP_PASS;
          MD_LIN:  cls.op = OP_LIN;
          MD_EXP:  cls.op = OP_EXP;
          MD_PEAK: cls.op = OP_PEAK;
          MD_ENRG: cls.op = OP_ENRG;
          default: cls.op = OP_HOLD;
        endcase
      end
      FN_READ:  cls.op = (mode == MD_ENRG) ? OP_RMS : OP_READ;
      FN_CLEAR: cls.op = OP_CLEAR;
      default:  cls.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item.valid && item.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      cmd <= cls;
    end
  end

endmodule

// ----- sv/sba_queue.sv -----
// ============================================================================
// sba_queue
// Short command FIFO between the front end and the back end.
// ============================================================================
module sba_queue
  import sba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/sba_div.sv -----
// ============================================================================
// sba_div
// Iterative unsigned divider, two quotient bits per cycle.
// ============================================================================
module sba_div
  import sba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0]  work;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    r_a;
  logic [DVS_W:0]    r_b;
  logic              ge_a;
  logic              ge_b;

  always_comb begin
    r_a  = {rem, work[DVD_W-1]};
    ge_a = r_a >= {1'b0, dvs};
    if (ge_a) begin
      r_a = r_a - {1'b0, dvs};
    end
    r_b  = {r_a[DVS_W-1:0], work[DVD_W-2]};
    ge_b = r_b >= {1'b0, dvs};
    if (ge_b) begin
      r_b = r_b - {1'b0, dvs};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;
  assign rsp.rem  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      work <= {work[DVD_W-3:0], ge_a, ge_b};
      rem  <= r_b[DVS_W-1:0];
    end
  end

endmodule

// ----- sv/sba_back.sv -----
// ============================================================================
// sba_back
// Executes commands: bin store, mode arithmetic, square root, frame count.
// ============================================================================
module sba_back
  import sba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  cmd_t        pop_cmd,
  input  logic [15:0] max_averages,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  sba_out_if.source   result
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_DST  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]         state;
  cmd_t               cur;
  addr_t              clr_cnt;
  logic [15:0]        frame_count;
  logic               done_flag;

  logic signed [47:0] mem [BINS];
  logic signed [47:0] rdata;
  logic               wr_en;
  addr_t              wr_addr;
  logic signed [47:0] wr_data;

  logic signed [47:0] s_reg;
  logic [47:0]        xsq;
  logic signed [49:0] d_reg;
  logic signed [49:0] q_reg;
  logic signed [47:0] acc;
  logic               fix;
  logic               floor_op;
  logic signed [47:0] res_value;

  logic [47:0]        sq_v;
  logic [47:0]        sq_res;
  logic [47:0]        sq_bit;
  logic [47:0]        sq_t;
  logic [47:0]        sq_v_next;
  logic [47:0]        sq_res_next;

  logic               ov;
  logic signed [47:0] o_value;
  logic [15:0]        o_frames;
  logic               o_done;

  logic [23:0]        magx;
  logic [47:0]        mags;
  logic signed [49:0] x50;
  logic signed [49:0] s50;
  logic signed [49:0] d_calc;
  logic [49:0]        uq;
  logic               rnz;
  logic [15:0]        fc_inc;
  logic               done_inc;
  logic               out_free;
  logic               uses_store;
  logic signed [47:0] wval;

  assign pop_ready = (state == S_IDLE);
  assign out_free  = !ov || result.ready;
  assign floor_op  = (cur.op == OP_LIN) || (cur.op == OP_ENRG);

  assign result.valid       = ov;
  assign result.value       = o_value;
  assign result.frames_done = o_frames;
  assign result.completed   = o_done;

  assign uses_store = (pop_cmd.op == OP_LIN) || (pop_cmd.op == OP_EXP) ||
                      (pop_cmd.op == OP_PEAK) || (pop_cmd.op == OP_ENRG) ||
                      (pop_cmd.op == OP_HOLD) || (pop_cmd.op == OP_READ) ||
                      (pop_cmd.op == OP_RMS);

  always_comb begin
    magx   = cur.sample[23] ? 24'(-cur.sample) : 24'(cur.sample);
    mags   = rdata[47] ? 48'(-rdata) : 48'(rdata);
    x50    = {{26{cur.sample[23]}}, cur.sample};
    s50    = {{2{rdata[47]}}, rdata};
    d_calc = ((cur.op == OP_ENRG) ? $signed({2'b00, xsq}) : x50) - s50;
  end

  always_comb begin
    uq  = div_rsp.quot;
    rnz = div_rsp.rem != '0;
  end

  always_comb begin
    sq_t = sq_res + sq_bit;
    if (sq_v >= sq_t) begin
      sq_v_next   = sq_v - sq_t;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  always_comb begin
    fc_inc   = (frame_count != 16'hFFFF) ? frame_count + 16'd1 : frame_count;
    done_inc = (max_averages != 16'd0) ? (fc_inc >= max_averages) : done_flag;
  end

  assign wval = acc + 48'(fix && acc[47]);

  always_comb begin
    div_req.start    = (state == S_DST);
    div_req.dividend = d_reg[49] ? 50'(-d_reg) : 50'(d_reg);
    div_req.divisor  = (cur.op == OP_EXP) ? {1'b0, max_averages}
                                          : {1'b0, frame_count} + 17'd1;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur.addr;
    wr_data = wval;
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      S_WR:    wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[cur.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_cnt     <= '0;
      frame_count <= '0;
      done_flag   <= 1'b0;
      ov          <= 1'b0;
    end else begin
      // a new result loaded in S_FIN keeps ov high
      if (ov && result.ready && !(state == S_FIN && out_free)) begin
        ov <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_valid) begin
            state <= (uses_store && pop_cmd.inrange) ? S_RD : S_FIN;
          end
        end
        S_RD:   state <= S_CALC;
        S_CALC: begin
          case (cur.op)
            OP_LIN, OP_ENRG: state <= S_DST;
            OP_EXP:          state <= (max_averages == 16'd0) ? S_WR : S_DST;
            OP_PEAK:         state <= S_WR;
            OP_RMS:          state <= S_SQRT;
            default:         state <= S_FIN;
          endcase
        end
        S_DST: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_ADD;
          end
        end
        S_ADD: state <= S_WR;
        S_SQRT: begin
          if (sq_bit[0]) begin
            state <= S_FIN;
          end
        end
        S_WR: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            ov <= 1'b1;
            if (cur.op == OP_CLEAR) begin
              frame_count <= '0;
              done_flag   <= 1'b0;
              clr_cnt     <= '0;
              state       <= S_CLR;
            end else begin
              if (cur.frame_end) begin
                frame_count <= fc_inc;
                done_flag   <= done_inc;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur       <= pop_cmd;
        res_value <= (pop_cmd.op == OP_PASS) ? 48'(pop_cmd.sample) : '0;
      end
      S_RD: xsq <= 48'(magx) * 48'(magx);
      S_CALC: begin
        s_reg  <= rdata;
        d_reg  <= d_calc;
        fix    <= 1'b0;
        sq_v   <= mags;
        sq_res <= '0;
        sq_bit <= 48'd1 << 46;
        case (cur.op)
          OP_EXP:  acc <= 48'(cur.sample);
          OP_PEAK: acc <= (48'(magx) > mags) ? 48'(cur.sample) : rdata;
          default: acc <= rdata;
        endcase
        res_value <= rdata;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fix <= floor_op && rnz;
          if (d_reg[49]) begin
            q_reg <= (floor_op && rnz) ? $signed(~uq) : $signed(~uq + 50'd1);
          end else begin
            q_reg <= $signed(uq);
          end
        end
      end
      S_ADD: begin
        acc <= 48'({{2{s_reg[47]}}, s_reg} + q_reg);
      end
      S_SQRT: begin
        sq_v   <= sq_v_next;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          res_value <= $signed(sq_res_next);
        end
      end
      S_WR: res_value <= wval;
      S_FIN: begin
        if (out_free) begin
          if (cur.op == OP_CLEAR) begin
            o_value  <= '0;
            o_frames <= '0;
            o_done   <= 1'b0;
          end else begin
            o_value  <= res_value;
            o_frames <= cur.frame_end ? fc_inc : frame_count;
            o_done   <= cur.frame_end ? done_inc : done_flag;
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pop_ready)
    else $error("command taken while back end busy");
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_WR || state == S_CLR))
    else $error("store written outside write or clear");
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (frame_count < $past(frame_count)) |-> $past(cur.op == OP_CLEAR))
    else $error("frame count dropped without clear");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == S_DIV && !div_rsp.done))
    else $error("divider start sequencing broken");
`endif

endmodule
